FILE: rtl/srtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtt_pkg: shared types and constants for the signed radix to text block
// Field widths, character codes, radix limits and sequencer states.
// ----------------------------------------------------------------------------
package srtt_pkg;

  // payload field widths
  localparam int unsigned IN_W    = 32;
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned CHAR_W  = 7;

  // one stored digit holds a remainder below the largest radix
  localparam int unsigned DIGIT_W = 6;

  // radix limits and reset value
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

  // ascii codes
  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
  // 'A' minus ten, so digit value ten maps to 'A'
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = CHAR_W'(55);
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = DIGIT_W'(10);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_EMIT
  } srtt_state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = CHAR_W'(d);
    return (d < DIGIT_TEN) ? (CHAR_ZERO + d_ext) : (CHAR_ALPHA + d_ext);
  endfunction

endpackage

FILE: rtl/signed_radix_to_text.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_radix_to_text: signed integer to ascii text in a radix of 2 to 36
// Bit-serial restoring divider under a small sequencer, digit stack, and a
// one-character output register.
// ----------------------------------------------------------------------------
// usage
//   input channel  : value, in_valid / in_stall. one transaction is one signed
//                    integer; only the low VALUE_BITS bits count, sign bit at
//                    VALUE_BITS-1. in_stall is high while a number is in work
//   output channel : char_code, last_char, out_valid / out_stall. one
//                    transaction per character: '-' for a negative value, then
//                    the digits most significant first; last_char marks the end
//   config channel : cfg_data, cfg_valid / cfg_ready. sets the radix (reset 10),
//                    0 and 1 act as 2, 37 and above act as 36
//   timing         : the shared divider makes the digits one after another,
//                    one quotient bit per cycle, least significant digit
//                    first; the characters then go out one at a time
//   reset          : synchronous, clears the sequencer and output valid and
//                    sets the radix to 10
//   back-pressure  : while out_stall holds, the character waits in the output
//                    register and the sequencer pauses before the next one
// ----------------------------------------------------------------------------
module signed_radix_to_text #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [srtt_pkg::RADIX_W-1:0]        cfg_data,
  // input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [srtt_pkg::IN_W-1:0]    value,
  // output characters
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [srtt_pkg::CHAR_W-1:0]         char_code,
  output logic                                last_char
);

  import srtt_pkg::*;

  localparam int unsigned BIT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

  srtt_state_t state, state_next;

  // configuration register, kept raw and clamped when a number starts
  logic [RADIX_W-1:0] radix;

  // divider working registers
  logic [RADIX_W-1:0]    divisor;   // clamped radix for this number
  logic [VALUE_BITS-1:0] work;      // dividend shifting out, quotient shifting in
  logic [DIGIT_W-1:0]    rem;       // partial remainder, always below divisor
  logic [BIT_W-1:0]      bit_cnt;   // quotient bit in progress
  logic                  neg;       // number was negative

  // digit stack: newest digit (most significant) at entry 0
  logic [VALUE_BITS-1:0][DIGIT_W-1:0] stack;
  logic [CNT_W-1:0]                   cnt;

  // accept / handshake terms
  logic in_take;
  logic out_free;
  logic load_sign;
  logic load_digit;

  // shared divider step
  logic [DIGIT_W:0]      rem_sh;
  logic                  q_bit;
  logic [DIGIT_W:0]      rem_sub;
  logic [DIGIT_W-1:0]    rem_new;
  logic [VALUE_BITS-1:0] work_new;
  logic                  last_bit;

  // input conditioning
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic [RADIX_W-1:0]    radix_eff;

  assign raw = VALUE_BITS'($unsigned(value));
  assign mag = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

  always_comb begin
    priority if (radix < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix;
    end
  end

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh   = {rem, work[VALUE_BITS-1]};
  assign q_bit    = (rem_sh >= {1'b0, divisor});
  assign rem_sub  = rem_sh - {1'b0, divisor};
  assign rem_new  = q_bit ? rem_sub[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
  assign work_new = {work[VALUE_BITS-2:0], q_bit};
  assign last_bit = (bit_cnt == BIT_W'(VALUE_BITS - 1));

  assign out_free = !out_valid || !out_stall;
  assign in_take  = in_valid && !in_stall;

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake outputs
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    cfg_ready  = 1'b0;
    load_sign  = 1'b0;
    load_digit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        // the number is done when the last quotient bit is in and the quotient is zero
        if (last_bit && (work_new == '0)) begin
          state_next = neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          load_sign  = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load_digit = 1'b1;
          if (cnt == CNT_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radix <= cfg_data;
    end
  end

  // divider datapath and digit stack
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      bit_cnt <= '0;
    end else begin
      if (in_take) begin
        divisor <= radix_eff;
        work    <= mag;
        neg     <= raw[VALUE_BITS-1];
        rem     <= '0;
        bit_cnt <= '0;
        cnt     <= '0;
      end else if (state == ST_DIVIDE) begin
        if (last_bit) begin
          // digit finished: push it and restart on the quotient
          stack   <= {stack[VALUE_BITS-2:0], rem_new};
          cnt     <= cnt + CNT_W'(1);
          rem     <= '0;
          bit_cnt <= '0;
        end else begin
          rem     <= rem_new;
          bit_cnt <= bit_cnt + BIT_W'(1);
        end
        work <= work_new;
      end else if (load_digit) begin
        stack <= {{DIGIT_W{1'b0}}, stack[VALUE_BITS-1:1]};
        cnt   <= cnt - CNT_W'(1);
      end
    end
  end

  // output register, one character at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_sign || load_digit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_sign) begin
      char_code <= CHAR_MINUS;
      last_char <= 1'b0;
    end else if (load_digit) begin
      char_code <= digit_char(stack[0]);
      last_char <= (cnt == CNT_W'(1));
    end
  end

  // checks on the sequencer and divider
  a_cnt_bound : assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(VALUE_BITS))
    else $error("digit count beyond capacity");

  a_rem_below_divisor : assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> (rem < divisor))
    else $error("partial remainder not below divisor");

  a_divisor_range : assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> (divisor >= RADIX_MIN && divisor <= RADIX_MAX))
    else $error("divisor out of radix range");

  a_emit_has_digit : assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT || state == ST_SIGN) |-> (cnt != '0))
    else $error("emitting with an empty digit stack");

  a_idle_after_last : assert property (@(posedge clk) disable iff (rst)
    load_digit && (cnt == CNT_W'(1)) |=> (state == ST_IDLE) && last_char)
    else $error("last digit did not end the number");

endmodule
